// ===== rtl/core/triangle_plane_clipper_unit_macros.svh =====
// Assertion macros shared by the triangle plane clipper RTL
`ifndef TRIANGLE_PLANE_CLIPPER_UNIT_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define TPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/tpc_pkg.sv =====
// Types, constants and codes of the triangle plane clipper
package tpc_pkg;

	localparam int CW       = 32;
	localparam int SW       = 50;
	localparam int MW       = 51;
	localparam int QW       = 31;
	localparam int FRAC     = 30;
	localparam int QDEPTH   = 8;
	localparam int QAW      = 3;
	localparam int CNTW     = 4;
	localparam int DCW      = 5;
	localparam int CFG_IDXW = 3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [2:0][CW-1:0] vtx_t;
	typedef logic signed [SW-1:0] dist_t;

	localparam coord_t PX_RESET = 32'sd0;
	localparam coord_t PY_RESET = 32'sd0;
	localparam coord_t PZ_RESET = 32'sd6554;
	localparam coord_t NX_RESET = 32'sd0;
	localparam coord_t NY_RESET = 32'sd0;
	localparam coord_t NZ_RESET = 32'sd65536;

	typedef struct packed {
		coord_t in_ax;
		coord_t in_ay;
		coord_t in_az;
		coord_t in_bx;
		coord_t in_by;
		coord_t in_bz;
		coord_t in_cx;
		coord_t in_cy;
		coord_t in_cz;
	} tri_req_t;

	typedef struct packed {
		coord_t out_ax;
		coord_t out_ay;
		coord_t out_az;
		coord_t out_bx;
		coord_t out_by;
		coord_t out_bz;
		coord_t out_cx;
		coord_t out_cy;
		coord_t out_cz;
		logic   last_piece;
	} piece_t;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_ONE,
		MODE_TWO
	} clip_mode_t;

	typedef enum logic [CFG_IDXW-1:0] {
		REG_PX,
		REG_PY,
		REG_PZ,
		REG_NX,
		REG_NY,
		REG_NZ
	} cfg_reg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM,
		B_DIV,
		B_MUL,
		B_SUM,
		B_EMIT0,
		B_EMIT1
	} back_state_t;

	typedef struct packed {
		vtx_t       v0;
		vtx_t       v1;
		vtx_t       v2;
		dist_t      s0;
		dist_t      s1;
		dist_t      s2;
		clip_mode_t mode;
	} work_t;

endpackage

// ===== rtl/core/triangle_plane_clipper_unit.sv =====
// Top level of the triangle plane clipper
// The front end takes one triangle per cycle whenever full is low and holds up to eight
// triangles between acceptance and the back end; a triangle with all vertices hidden is
// dropped there and yields no result. A triangle with all vertices visible goes from idle
// straight to the result state of the back end. A clipped triangle passes through
// normalization, the bit-serial divider that forms both intersection fractions side by
// side, then multiply, round and one or two result states, and the back end takes no
// new triangle meanwhile. That divider sets the sustained rate for clipped geometry.
module triangle_plane_clipper_unit import tpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tri_req_t            triangle,
	output logic                empty,
	input  logic                pop,
	output piece_t              piece,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IDXW-1:0] cfg_index,
	input  logic [CW-1:0]       cfg_data
);

	logic  wr_en, work_empty, work_pop;
	work_t wr_data, work;

	tpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.triangle    (triangle),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.release_req (work_pop),
		.wr_en       (wr_en),
		.wr_data     (wr_data)
	);

	tpc_work_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (work_pop),
		.rd_data (work),
		.empty   (work_empty)
	);

	tpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (work),
		.work_empty (work_empty),
		.work_pop   (work_pop),
		.pop        (pop),
		.empty      (empty),
		.piece      (piece)
	);

endmodule

// ===== rtl/core/tpc_front.sv =====
// Front end: plane registers, distance pipeline, classification and credit count
module tpc_front import tpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tri_req_t            triangle,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IDXW-1:0] cfg_index,
	input  logic [CW-1:0]       cfg_data,
	input  logic                release_req,
	output logic                wr_en,
	output work_t               wr_data
);
`include "triangle_plane_clipper_unit_macros.svh"

	coord_t px_q, py_q, pz_q, nx_q, ny_q, nz_q;
	coord_t pt [3];
	coord_t nrm [3];
	vtx_t   vin [3];

	logic   accept;
	logic   valid_s1, valid_s2, valid_s3;
	vtx_t   vtx_s1 [3];
	vtx_t   vtx_s2 [3];
	vtx_t   vtx_s3 [3];
	coord_t d_s1 [3][3];
	logic signed [63:0] prod_s2 [3][3];
	dist_t  dist_s3 [3];

	logic [2:0] vis;
	logic [1:0] nv;
	logic       drop;
	logic [CNTW-1:0] credit_q;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign full      = (credit_q == CNTW'(QDEPTH));

	assign pt[0]  = px_q;
	assign pt[1]  = py_q;
	assign pt[2]  = pz_q;
	assign nrm[0] = nx_q;
	assign nrm[1] = ny_q;
	assign nrm[2] = nz_q;
	assign vin[0] = {triangle.in_az, triangle.in_ay, triangle.in_ax};
	assign vin[1] = {triangle.in_bz, triangle.in_by, triangle.in_bx};
	assign vin[2] = {triangle.in_cz, triangle.in_cy, triangle.in_cx};

	function automatic coord_t sat_sub(coord_t a, coord_t b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		if (d[CW] != d[CW-1]) begin
			sat_sub = d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat_sub = d[CW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PX_RESET;
			py_q <= PY_RESET;
			pz_q <= PZ_RESET;
			nx_q <= NX_RESET;
			ny_q <= NY_RESET;
			nz_q <= NZ_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PX: px_q <= cfg_data;
				REG_PY: py_q <= cfg_data;
				REG_PZ: pz_q <= cfg_data;
				REG_NX: nx_q <= cfg_data;
				REG_NY: ny_q <= cfg_data;
				REG_NZ: nz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vtx_s1[i] <= vin[i];
			vtx_s2[i] <= vtx_s1[i];
			vtx_s3[i] <= vtx_s2[i];
			for (int k = 0; k < 3; k++) begin
				d_s1[i][k]    <= sat_sub($signed(vin[i][k]), pt[k]);
				prod_s2[i][k] <= d_s1[i][k] * nrm[k];
			end
			dist_s3[i] <= SW'(prod_s2[i][0] >>> 16) + SW'(prod_s2[i][1] >>> 16)
				+ SW'(prod_s2[i][2] >>> 16);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vis[i] = !dist_s3[i][SW-1];
		end
		nv = 2'(vis[0]) + 2'(vis[1]) + 2'(vis[2]);
		wr_data.v0   = vtx_s3[0];
		wr_data.v1   = vtx_s3[1];
		wr_data.v2   = vtx_s3[2];
		wr_data.s0   = dist_s3[0];
		wr_data.s1   = dist_s3[1];
		wr_data.s2   = dist_s3[2];
		wr_data.mode = MODE_PASS;
		drop         = 1'b0;
		unique case (nv)
			2'd0: drop = valid_s3;
			2'd1: begin
				wr_data.mode = MODE_ONE;
				if (vis[1]) begin
					wr_data.v0 = vtx_s3[1];
					wr_data.v1 = vtx_s3[0];
					wr_data.s0 = dist_s3[1];
					wr_data.s1 = dist_s3[0];
				end else if (vis[2]) begin
					wr_data.v0 = vtx_s3[2];
					wr_data.v2 = vtx_s3[0];
					wr_data.s0 = dist_s3[2];
					wr_data.s2 = dist_s3[0];
				end
			end
			2'd2: begin
				wr_data.mode = MODE_TWO;
				if (!vis[1]) begin
					wr_data.v0 = vtx_s3[1];
					wr_data.v1 = vtx_s3[0];
					wr_data.s0 = dist_s3[1];
					wr_data.s1 = dist_s3[0];
				end else if (!vis[2]) begin
					wr_data.v0 = vtx_s3[2];
					wr_data.v2 = vtx_s3[0];
					wr_data.s0 = dist_s3[2];
					wr_data.s2 = dist_s3[0];
				end
			end
			default: wr_data.mode = MODE_PASS;
		endcase
	end

	assign wr_en = valid_s3 && (nv != 2'd0);

	// one credit per triangle from acceptance until the back end takes it or it is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNTW'(accept) - CNTW'(release_req) - CNTW'(drop);
		end
	end

	`TPC_NEVER(a_credit_bound, credit_q > CNTW'(QDEPTH), "credit count above queue depth")
	`TPC_ASSERT(a_push_has_credit, wr_en |-> (credit_q != '0), "queue write without credit")
	`TPC_ASSERT(a_drop_no_write, drop |-> !wr_en, "dropped triangle also queued")

endmodule

// ===== rtl/core/tpc_work_fifo.sv =====
// Queue of classified triangles between front and back end
module tpc_work_fifo import tpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  work_t wr_data,
	input  logic  rd_en,
	output work_t rd_data,
	output logic  empty
);

	work_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wptr_q, rptr_q;
	logic [CNTW-1:0] count_q;

	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + CNTW'(wr_en) - CNTW'(rd_en);
		end
	end

endmodule

// ===== rtl/core/tpc_back.sv =====
// Back end: intersection sequencer with serial divider and result queue
module tpc_back import tpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  work_t  work,
	input  logic   work_empty,
	output logic   work_pop,
	input  logic   pop,
	output logic   empty,
	output piece_t piece
);
`include "triangle_plane_clipper_unit_macros.svh"

	back_state_t state_q, state_d;
	work_t       cur_q;
	logic [MW-1:0] num0_q, num1_q, den0_q, den1_q;
	logic [CW:0]   rem0_q, rem1_q;
	logic [QW-1:0] quo0_q, quo1_q;
	logic [DCW-1:0] cnt_q;
	logic signed [64:0] prod0_q [3];
	logic signed [64:0] prod1_q [3];
	vtx_t ipt0_q, ipt1_q;

	piece_t ofifo_q [2];
	logic   owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic   ofull, owr_en, ord_en;
	piece_t owr_data;

	logic norm_done, div_done;
	logic [CW:0] sh0, sh1;
	logic ge0, ge1;
	logic [QW-1:0] f0, f1;

	function automatic piece_t make_piece(vtx_t a, vtx_t b, vtx_t c, logic last);
		piece_t p;
		p.out_ax = a[0];
		p.out_ay = a[1];
		p.out_az = a[2];
		p.out_bx = b[0];
		p.out_by = b[1];
		p.out_bz = b[2];
		p.out_cx = c[0];
		p.out_cy = c[1];
		p.out_cz = c[2];
		p.last_piece = last;
		return p;
	endfunction

	function automatic logic [MW-1:0] mag(dist_t s);
		return s[SW-1] ? MW'(-s) : MW'(s);
	endfunction

	assign norm_done = (den0_q[MW-1:CW] == '0) && (den1_q[MW-1:CW] == '0);
	assign div_done  = (cnt_q == DCW'(QW - 1));
	assign sh0 = (cnt_q == '0) ? rem0_q : {rem0_q[CW-1:0], 1'b0};
	assign sh1 = (cnt_q == '0) ? rem1_q : {rem1_q[CW-1:0], 1'b0};
	assign ge0 = sh0 >= {1'b0, den0_q[CW-1:0]};
	assign ge1 = sh1 >= {1'b0, den1_q[CW-1:0]};
	assign f0  = (den0_q == '0) ? '0 : quo0_q;
	assign f1  = (den1_q == '0) ? '0 : quo1_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!work_empty) begin
					state_d = (work.mode == MODE_PASS) ? B_EMIT1 : B_NORM;
				end
			end
			B_NORM:  if (norm_done) state_d = B_DIV;
			B_DIV:   if (div_done) state_d = B_MUL;
			B_MUL:   state_d = B_SUM;
			B_SUM:   state_d = (cur_q.mode == MODE_TWO) ? B_EMIT0 : B_EMIT1;
			B_EMIT0: if (!ofull) state_d = B_EMIT1;
			B_EMIT1: if (!ofull) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		work_pop = 1'b0;
		owr_en   = 1'b0;
		owr_data = make_piece(cur_q.v0, cur_q.v1, cur_q.v2, 1'b1);
		unique case (state_q)
			B_IDLE:  work_pop = !work_empty;
			B_EMIT0: begin
				owr_en   = !ofull;
				owr_data = make_piece(cur_q.v1, ipt0_q, cur_q.v2, 1'b0);
			end
			B_EMIT1: begin
				owr_en = !ofull;
				unique case (cur_q.mode)
					MODE_ONE: owr_data = make_piece(cur_q.v0, ipt0_q, ipt1_q, 1'b1);
					MODE_TWO: owr_data = make_piece(cur_q.v2, ipt0_q, ipt1_q, 1'b1);
					default:  owr_data = make_piece(cur_q.v0, cur_q.v1, cur_q.v2, 1'b1);
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				cur_q  <= work;
				num0_q <= mag(work.s0);
				num1_q <= mag(work.s0);
				den0_q <= mag(work.s0) + mag(work.s1);
				den1_q <= mag(work.s0) + mag(work.s2);
			end
			B_NORM: begin
				if (den0_q[MW-1:CW] != '0) begin
					num0_q <= num0_q >> 1;
					den0_q <= den0_q >> 1;
				end
				if (den1_q[MW-1:CW] != '0) begin
					num1_q <= num1_q >> 1;
					den1_q <= den1_q >> 1;
				end
				rem0_q <= {1'b0, num0_q[CW-1:0]};
				rem1_q <= {1'b0, num1_q[CW-1:0]};
				quo0_q <= '0;
				quo1_q <= '0;
				cnt_q  <= '0;
			end
			B_DIV: begin
				rem0_q <= ge0 ? sh0 - {1'b0, den0_q[CW-1:0]} : sh0;
				rem1_q <= ge1 ? sh1 - {1'b0, den1_q[CW-1:0]} : sh1;
				quo0_q <= {quo0_q[QW-2:0], ge0};
				quo1_q <= {quo1_q[QW-2:0], ge1};
				cnt_q  <= cnt_q + 1'b1;
			end
			B_MUL: begin
				for (int k = 0; k < 3; k++) begin
					prod0_q[k] <= ($signed({cur_q.v1[k][CW-1], cur_q.v1[k]})
						- $signed({cur_q.v0[k][CW-1], cur_q.v0[k]})) * $signed({1'b0, f0});
					prod1_q[k] <= ($signed({cur_q.v2[k][CW-1], cur_q.v2[k]})
						- $signed({cur_q.v0[k][CW-1], cur_q.v0[k]})) * $signed({1'b0, f1});
				end
			end
			B_SUM: begin
				for (int k = 0; k < 3; k++) begin
					ipt0_q[k] <= cur_q.v0[k]
						+ CW'((prod0_q[k] + 65'sd536870912) >>> FRAC);
					ipt1_q[k] <= cur_q.v0[k]
						+ CW'((prod1_q[k] + 65'sd536870912) >>> FRAC);
				end
			end
			default: ;
		endcase
	end

	// two-entry result queue
	assign ofull  = (ocnt_q == 2'd2);
	assign empty  = (ocnt_q == 2'd0);
	assign ord_en = pop && !empty;
	assign piece  = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (owr_en) begin
			ofifo_q[owr_q] <= owr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (owr_en) begin
				owr_q <= !owr_q;
			end
			if (ord_en) begin
				ord_q <= !ord_q;
			end
			ocnt_q <= ocnt_q + 2'(owr_en) - 2'(ord_en);
		end
	end

	`TPC_NEVER(a_ocnt_bound, ocnt_q > 2'd2, "result queue count above two")
	`TPC_ASSERT(a_div_normed, (state_q == B_DIV) |-> norm_done, "divide on unnormalized denominator")
	`TPC_ASSERT(a_emit0_two, (state_q == B_EMIT0) |-> (cur_q.mode == MODE_TWO), "first piece of a single-piece triangle")
	`TPC_ASSERT(a_pop_idle, work_pop |=> (state_q != B_IDLE), "work taken but sequencer stayed idle")

endmodule

// ===== tb/sv/triangle_plane_clipper_unit_test.sv =====
// Self-checking testbench of the triangle plane clipper: directed table, then random triangles
`timescale 1ns / 1ps
module triangle_plane_clipper_unit_test import tpc_pkg::*; ();

	typedef longint signed vec3_t [3];

	typedef struct {
		tri_req_t req;
		bit       typed;
		bit       has_piece;
		piece_t   piece;
	} stim_row_t;

	localparam logic [CFG_IDXW-1:0] REG_UNUSED = 3'd6;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int SETTLE = 600;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	tri_req_t            triangle;
	logic                empty;
	logic                pop;
	piece_t              piece;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IDXW-1:0] cfg_index;
	logic [CW-1:0]       cfg_data;

	longint signed plane_pt [3];
	longint signed plane_nrm [3];
	piece_t pending_pieces [$];
	int errors;
	bit quiet;
	bit hold_go;
	bit hold_done;
	int stall_cnt;
	int hold_cnt;

	triangle_plane_clipper_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .triangle(triangle),
		.empty(empty), .pop(pop), .piece(piece), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#12ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint signed plane_dist(vec3_t c);
		longint signed d, s;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			d = c[k] - plane_pt[k];
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			if (d < -64'sd2147483648) d = -64'sd2147483648;
			s += (plane_nrm[k] * d) >>> 16;
		end
		return s;
	endfunction

	function automatic void cut_point(vec3_t a, longint signed sa, vec3_t b,
			longint signed sb, output vec3_t r);
		longint unsigned num, den, f;
		num = (sa < 0) ? -sa : sa;
		den = num + ((sb < 0) ? -sb : sb);
		while (den >= 64'h1_0000_0000) begin
			num = num >> 1;
			den = den >> 1;
		end
		f = (den != 0) ? (num << 30) / den : 0;
		for (int k = 0; k < 3; k++)
			r[k] = a[k] + (((b[k] - a[k]) * $signed(f) + (64'sd1 <<< 29)) >>> 30);
	endfunction

	function automatic piece_t make_piece(vec3_t p, vec3_t q, vec3_t r, bit last);
		piece_t o;
		o.out_ax = p[0][31:0]; o.out_ay = p[1][31:0]; o.out_az = p[2][31:0];
		o.out_bx = q[0][31:0]; o.out_by = q[1][31:0]; o.out_bz = q[2][31:0];
		o.out_cx = r[0][31:0]; o.out_cy = r[1][31:0]; o.out_cz = r[2][31:0];
		o.last_piece = last;
		return o;
	endfunction

	function automatic void clip_triangle(tri_req_t t);
		vec3_t v [3];
		vec3_t tv, i0, i1;
		longint signed s [3];
		longint signed ts;
		int nv, j;
		v[0][0] = t.in_ax; v[0][1] = t.in_ay; v[0][2] = t.in_az;
		v[1][0] = t.in_bx; v[1][1] = t.in_by; v[1][2] = t.in_bz;
		v[2][0] = t.in_cx; v[2][1] = t.in_cy; v[2][2] = t.in_cz;
		nv = 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = plane_dist(v[i]);
			if (s[i] >= 0) nv++;
		end
		if (nv == 0) return;
		if (nv == 3) begin
			pending_pieces.push_back(make_piece(v[0], v[1], v[2], 1'b1));
			return;
		end
		j = 0;
		if (nv == 1) begin
			if (s[1] >= 0) j = 1;
			else if (s[2] >= 0) j = 2;
		end else begin
			if (s[1] < 0) j = 1;
			else if (s[2] < 0) j = 2;
		end
		if (j != 0) begin
			tv = v[0]; v[0] = v[j]; v[j] = tv;
			ts = s[0]; s[0] = s[j]; s[j] = ts;
		end
		cut_point(v[0], s[0], v[1], s[1], i0);
		cut_point(v[0], s[0], v[2], s[2], i1);
		if (nv == 1) begin
			pending_pieces.push_back(make_piece(v[0], i0, i1, 1'b1));
		end else begin
			pending_pieces.push_back(make_piece(v[1], i0, v[2], 1'b0));
			pending_pieces.push_back(make_piece(v[2], i0, i1, 1'b1));
		end
	endfunction

	// result side: check accepted pieces, random pop stalls, one long hold-off
	always @(posedge clk) begin
		piece_t want;
		if (arst_n && pop && !empty) begin
			if (pending_pieces.size() == 0) begin
				$display("%t unexpected piece: expected none actual %h", $time, piece);
				errors++;
			end else begin
				want = pending_pieces.pop_front();
				for (int k = 0; k < 9; k++)
					if (want[1 + CW*(8-k) +: CW] !== piece[1 + CW*(8-k) +: CW]) begin
						$display("%t coord %0d: expected %h actual %h", $time, k,
							want[1 + CW*(8-k) +: CW], piece[1 + CW*(8-k) +: CW]);
						errors++;
					end
				if (want.last_piece !== piece.last_piece) begin
					$display("%t last_piece: expected %b actual %b", $time,
						want.last_piece, piece.last_piece);
					errors++;
				end
			end
		end
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_cnt = $urandom_range(1, 18) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// called at a rising edge; returns at the edge that accepted the request
	task automatic send_triangle(tri_req_t t);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		push <= 1'b1;
		triangle <= t;
		do @(posedge clk); while (full);
		clip_triangle(t);
	endtask

	task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [CW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_NZ) begin
			if (idx < REG_NX) plane_pt[idx] = $signed(val);
			else plane_nrm[idx - REG_NX] = $signed(val);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		push <= 1'b0;
		wait (pending_pieces.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(longint signed center);
		if ($urandom_range(0, 7) == 0) return $urandom;
		return CW'(center + $urandom_range(0, 2**21) - 2**20);
	endfunction

	function automatic logic [CW-1:0] rand_reg();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return CW'($urandom_range(0, 2**18) - 2**17);
	endfunction

	function automatic tri_req_t tri_of(vec3_t a, vec3_t b, vec3_t c);
		tri_req_t t;
		t.in_ax = a[0]; t.in_ay = a[1]; t.in_az = a[2];
		t.in_bx = b[0]; t.in_by = b[1]; t.in_bz = b[2];
		t.in_cx = c[0]; t.in_cy = c[1]; t.in_cz = c[2];
		return t;
	endfunction

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		tri_req_t t;
		logic [CW-1:0] vals [6];
		vec3_t a, b, c;
		longint signed pz;
		errors = 0;
		quiet = 1'b0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		stall_cnt = 0;
		hold_cnt = 0;
		plane_pt = '{0, 0, 6554};
		plane_nrm = '{0, 0, 65536};
		arst_n <= 1'b0;
		push <= 1'b0;
		triangle <= '0;
		pop <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PX;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// all visible passes unchanged
		row.typed = 1; row.has_piece = 1;
		a = '{0, 0, 65536}; b = '{65536, 0, 65536}; c = '{0, 65536, 131072};
		row.req = tri_of(a, b, c); row.piece = make_piece(a, b, c, 1'b1); rows.push_back(row);
		// vertices exactly on the plane count as visible
		a = '{-5, 7, 6554}; b = '{100, -3, 6554}; c = '{9, 9, 6554};
		row.req = tri_of(a, b, c); row.piece = make_piece(a, b, c, 1'b1); rows.push_back(row);
		a = '{2147483647, 2147483647, 2147483647}; b = a; c = a;
		row.req = tri_of(a, b, c); row.piece = make_piece(a, b, c, 1'b1); rows.push_back(row);
		// all hidden: no piece
		row.has_piece = 0;
		a = '{0, 0, 0}; b = '{65536, 0, 6553}; c = '{0, 65536, -65536};
		row.req = tri_of(a, b, c); rows.push_back(row);
		a = '{-2147483648, -2147483648, -2147483648}; b = a; c = a;
		row.req = tri_of(a, b, c); rows.push_back(row);
		// one and two visible in every position, plus extreme spans
		row.typed = 0;
		a = '{0, 0, 131072}; b = '{65536, 0, -65536}; c = '{0, 65536, -65536};
		row.req = tri_of(a, b, c); rows.push_back(row);
		row.req = tri_of(b, a, c); rows.push_back(row);
		row.req = tri_of(b, c, a); rows.push_back(row);
		a = '{0, 0, -131072}; b = '{65536, 0, 65536}; c = '{0, 65536, 6554};
		row.req = tri_of(a, b, c); rows.push_back(row);
		row.req = tri_of(b, a, c); rows.push_back(row);
		row.req = tri_of(b, c, a); rows.push_back(row);
		a = '{2147483647, -2147483648, 2147483647};
		b = '{-2147483648, 2147483647, -2147483648};
		c = '{0, 0, -2147483648};
		row.req = tri_of(a, b, c); rows.push_back(row);
		row.req = tri_of(a, a, b); rows.push_back(row);
		a = '{0, 0, 6554}; b = '{0, 0, 6553}; c = '{1, 1, 6553};
		row.req = tri_of(a, b, c); rows.push_back(row);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				push <= 1'b1;
				triangle <= rows[i].req;
				do @(posedge clk); while (full);
				if (rows[i].has_piece) pending_pieces.push_back(rows[i].piece);
			end else begin
				send_triangle(rows[i].req);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
						32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
					2: vals = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
						32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
					3: vals = '{rand_reg(), rand_reg(), rand_reg(), 0, 0, 0};
					default: foreach (vals[k]) vals[k] = rand_reg();
				endcase
				for (int k = 0; k <= REG_NZ; k++) write_reg(k[CFG_IDXW-1:0], vals[k]);
				write_reg(REG_UNUSED, $urandom);
				write_reg(REG_UNUSED + 3'd1, $urandom);
			end
			pz = plane_pt[2];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == 20) hold_go = 1'b1;
				if (ph == PHASES - 1 && n == ITEMS_PER_PHASE - 100) quiet = 1'b1;
				t.in_ax = rand_coord(plane_pt[0]); t.in_ay = rand_coord(plane_pt[1]);
				t.in_az = rand_coord(pz);
				t.in_bx = rand_coord(plane_pt[0]); t.in_by = rand_coord(plane_pt[1]);
				t.in_bz = rand_coord(pz);
				t.in_cx = rand_coord(plane_pt[0]); t.in_cy = rand_coord(plane_pt[1]);
				t.in_cz = rand_coord(pz);
				send_triangle(t);
			end
		end

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
